// File: rtl/wame_pkg.sv
// shared types, sizes and codes for the weighted adjacency matrix engine
// no dependencies; used by the top level and the testbench
`default_nettype none

package wame_pkg;

	// graph size and derived widths
	localparam int NODES    = 8;
	localparam int NODE_W   = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CELLS    = NODES * NODES;
	localparam int ADDR_W   = $clog2(CELLS);

	// fixed field widths of the channels
	localparam int NODE_IN_W = 5;
	localparam int WEIGHT_W  = 8;
	localparam int KIND_W    = 2;

	// command codes
	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_MODIFY = 1'b1;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_NEIGHBOR = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_ERROR    = 2'd2
	} kind_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WR2,
		ST_SCAN
	} state_t;

	// flat matrix address of entry [row][col]
	function automatic logic [ADDR_W-1:0] wame_addr(input logic [NODE_W-1:0] row,
		input logic [NODE_W-1:0] col);
		return ADDR_W'(row) * ADDR_W'(NODES) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

// File: rtl/wame_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module wame_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/weighted_adjacency_matrix_engine.sv
// Weighted undirected adjacency matrix engine, one item at a time; uses wame_pkg and wame_ram.
// Modify: a self-loop writes its one entry in EXEC, else EXEC and WR2 write both entries
// (one ram write port). Query: row neighbours are read lowest first, one read in flight,
// each via the read stage to the output register; error and empty-row beats come from EXEC.
// Reset (async, active low) clears the nonzero flags, so every weight reads as zero;
// no clearing pass is needed and in_ready is high as soon as reset is released.
`default_nettype none

module weighted_adjacency_matrix_engine (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            command,
	input  wire logic [wame_pkg::NODE_IN_W-1:0]  first_node,
	input  wire logic [wame_pkg::NODE_IN_W-1:0]  second_node,
	input  wire logic [wame_pkg::WEIGHT_W-1:0]   edge_weight,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [wame_pkg::KIND_W-1:0]     kind,
	output logic      [wame_pkg::NODE_IN_W-1:0]  neighbor,
	output logic      [wame_pkg::WEIGHT_W-1:0]   weight,
	output logic                                 last
);

	wame_pkg::state_t state_q, state_d;

	// captured item
	logic                             cmd_q;
	logic [wame_pkg::NODE_IN_W-1:0]   a_q;
	logic [wame_pkg::NODE_IN_W-1:0]   b_q;
	logic [wame_pkg::WEIGHT_W-1:0]    w_q;

	// per-entry nonzero flags and remaining row neighbours
	logic [wame_pkg::CELLS-1:0]       nz_q;
	logic [wame_pkg::NODES-1:0]       rem_q;

	// read stage
	logic                             rd_s1;
	logic [wame_pkg::NODE_W-1:0]      idx_s1;
	logic                             last_s1;

	// output register
	logic                             out_valid_q;
	logic [wame_pkg::KIND_W-1:0]      kind_q;
	logic [wame_pkg::NODE_IN_W-1:0]   neighbor_q;
	logic [wame_pkg::WEIGHT_W-1:0]    weight_q;
	logic                             last_q;

	// decode
	logic                             a_bad, b_bad, slot_free;
	logic [wame_pkg::NODE_W-1:0]      row, col, pick_idx;
	logic [wame_pkg::ADDR_W-1:0]      addr_ab, addr_ba, row_base;
	logic [wame_pkg::NODES-1:0]       row_mask, rem_next;
	logic                             rem_last;

	// control from the sequencer
	logic                             ram_we, ram_re, rem_load, exec_emit;
	logic [wame_pkg::ADDR_W-1:0]      ram_waddr;
	logic [wame_pkg::KIND_W-1:0]      exec_kind;
	logic [wame_pkg::WEIGHT_W-1:0]    ram_rdata;

	// range checks and addresses
	assign a_bad     = a_q >= wame_pkg::NODE_IN_W'(wame_pkg::NODES);
	assign b_bad     = b_q >= wame_pkg::NODE_IN_W'(wame_pkg::NODES);
	assign row       = a_q[wame_pkg::NODE_W-1:0];
	assign col       = b_q[wame_pkg::NODE_W-1:0];
	assign addr_ab   = wame_pkg::wame_addr(row, col);
	assign addr_ba   = wame_pkg::wame_addr(col, row);
	assign row_base  = wame_pkg::wame_addr(row, '0);
	assign row_mask  = nz_q[row_base +: wame_pkg::NODES];
	assign slot_free = !out_valid_q || out_ready;

	// lowest remaining neighbour
	always_comb begin
		pick_idx = '0;
		for (int i = wame_pkg::NODES - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pick_idx = wame_pkg::NODE_W'(i);
			end
		end
	end

	assign rem_next = rem_q & (rem_q - wame_pkg::NODES'(1));
	assign rem_last = rem_next == '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wame_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = wame_pkg::ST_EXEC;
				end
			end
			wame_pkg::ST_EXEC: begin
				if (cmd_q == wame_pkg::CMD_MODIFY) begin
					if (a_bad || b_bad) begin
						if (slot_free) begin
							state_d = wame_pkg::ST_IDLE;
						end
					end else if (a_q == b_q) begin
						state_d = wame_pkg::ST_IDLE;
					end else begin
						state_d = wame_pkg::ST_WR2;
					end
				end else if (a_bad || row_mask == '0) begin
					if (slot_free) begin
						state_d = wame_pkg::ST_IDLE;
					end
				end else begin
					state_d = wame_pkg::ST_SCAN;
				end
			end
			wame_pkg::ST_WR2: begin
				state_d = wame_pkg::ST_IDLE;
			end
			wame_pkg::ST_SCAN: begin
				if (!rd_s1 && slot_free && rem_last) begin
					state_d = wame_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wame_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_ab;
		ram_re    = 1'b0;
		rem_load  = 1'b0;
		exec_emit = 1'b0;
		exec_kind = wame_pkg::KIND_ERROR;
		case (state_q)
			wame_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			wame_pkg::ST_EXEC: begin
				if (cmd_q == wame_pkg::CMD_MODIFY) begin
					if (a_bad || b_bad) begin
						exec_emit = slot_free;
					end else begin
						ram_we = 1'b1;
					end
				end else if (a_bad) begin
					exec_emit = slot_free;
				end else if (row_mask == '0) begin
					exec_emit = slot_free;
					exec_kind = wame_pkg::KIND_EMPTY;
				end else begin
					rem_load = 1'b1;
				end
			end
			wame_pkg::ST_WR2: begin
				ram_we    = 1'b1;
				ram_waddr = addr_ba;
			end
			wame_pkg::ST_SCAN: begin
				ram_re = !rd_s1 && slot_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// weight memory
	wame_ram #(
		.WIDTH(wame_pkg::WEIGHT_W),
		.DEPTH(wame_pkg::CELLS)
	) u_weights (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(w_q),
		.re   (ram_re),
		.raddr(wame_pkg::wame_addr(row, pick_idx)),
		.rdata(ram_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wame_pkg::ST_IDLE;
			nz_q        <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= ram_re;
			if (ram_we) begin
				nz_q[ram_waddr] <= w_q != '0;
			end
			if (rd_s1 || exec_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= command;
			a_q   <= first_node;
			b_q   <= second_node;
			w_q   <= edge_weight;
		end
		if (rem_load) begin
			rem_q <= row_mask;
		end else if (ram_re) begin
			rem_q <= rem_next;
		end
		if (ram_re) begin
			idx_s1  <= pick_idx;
			last_s1 <= rem_last;
		end
		if (rd_s1) begin
			kind_q     <= wame_pkg::KIND_NEIGHBOR;
			neighbor_q <= wame_pkg::NODE_IN_W'(idx_s1);
			weight_q   <= ram_rdata;
			last_q     <= last_s1;
		end else if (exec_emit) begin
			kind_q     <= exec_kind;
			neighbor_q <= '0;
			weight_q   <= '0;
			last_q     <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign neighbor  = neighbor_q;
	assign weight    = weight_q;
	assign last      = last_q;

	// a returning read always finds the output register empty
	a_read_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |-> !out_valid_q)
		else $error("read data returned while output register still full");

	// scanning only while neighbours remain
	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wame_pkg::ST_SCAN) |-> (rem_q != '0))
		else $error("scan state with no remaining neighbours");

	// a neighbour beat never carries a zero weight
	a_nb_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == wame_pkg::KIND_NEIGHBOR) |-> (weight_q != '0))
		else $error("neighbour beat with zero weight");

	// a new item is never taken while a read is in flight and another read is being issued
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (!rd_s1 || !ram_re))
		else $error("item accepted during a read issue");

endmodule

`default_nettype wire

// File: tb/weighted_adjacency_matrix_engine_test.sv
// self-checking testbench for the weighted adjacency matrix engine
// a directed table of items, then random edge edits and neighbour queries, checked beat by beat
// depends on wame_pkg and weighted_adjacency_matrix_engine
`default_nettype none

module weighted_adjacency_matrix_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 450;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int IDLE_PERCENT  = 13;
	localparam int DRAIN_CYCLES  = 8;
	localparam int CALM_FIRST    = 150;
	localparam int CALM_LAST     = 250;
	localparam int DIRECTED_ROWS = 25;

	// one row of the directed table; fixed marks a typed-in single result
	typedef struct packed {
		logic                           cmd;
		logic [wame_pkg::NODE_IN_W-1:0] node_a;
		logic [wame_pkg::NODE_IN_W-1:0] node_b;
		logic [wame_pkg::WEIGHT_W-1:0]  new_weight;
		logic                           fixed;
		wame_pkg::kind_t                fixed_kind;
	} stim_row_t;

	// one expected output beat
	typedef struct {
		wame_pkg::kind_t                kind;
		logic [wame_pkg::NODE_IN_W-1:0] neighbor;
		logic [wame_pkg::WEIGHT_W-1:0]  weight;
		logic                           last;
	} adj_beat_t;

	localparam logic [wame_pkg::NODE_IN_W-1:0] TOP_NODE =
		wame_pkg::NODE_IN_W'(wame_pkg::NODES - 1);
	localparam logic [wame_pkg::NODE_IN_W-1:0] BAD_NODE =
		wame_pkg::NODE_IN_W'(wame_pkg::NODES);

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{wame_pkg::CMD_QUERY,  5'd0,     5'd0,     8'd0,   1'b1, wame_pkg::KIND_EMPTY},
		'{wame_pkg::CMD_QUERY,  TOP_NODE, 5'd31,    8'd255, 1'b1, wame_pkg::KIND_EMPTY},
		'{wame_pkg::CMD_QUERY,  5'd31,    5'd0,     8'd0,   1'b1, wame_pkg::KIND_ERROR},
		'{wame_pkg::CMD_QUERY,  BAD_NODE, 5'd0,     8'd0,   1'b1, wame_pkg::KIND_ERROR},
		'{wame_pkg::CMD_MODIFY, BAD_NODE, 5'd0,     8'd255, 1'b1, wame_pkg::KIND_ERROR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     5'd31,    8'd1,   1'b1, wame_pkg::KIND_ERROR},
		'{wame_pkg::CMD_MODIFY, 5'd31,    5'd31,    8'd255, 1'b1, wame_pkg::KIND_ERROR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     TOP_NODE, 8'd255, 1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd3,     5'd3,     8'd1,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     5'd1,     8'd128, 1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     5'd3,     8'd17,  1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd0,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  TOP_NODE, 5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd3,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     5'd0,     8'd255, 1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd0,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd0,     TOP_NODE, 8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd0,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  TOP_NODE, 5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd3,     5'd3,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd3,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd1,     5'd2,     8'd85,  1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_MODIFY, 5'd2,     TOP_NODE, 8'd170, 1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd2,     5'd0,     8'd0,   1'b0, wame_pkg::KIND_NEIGHBOR},
		'{wame_pkg::CMD_QUERY,  5'd1,     5'd21,    8'd42,  1'b0, wame_pkg::KIND_NEIGHBOR}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic                           command;
	logic [wame_pkg::NODE_IN_W-1:0] first_node;
	logic [wame_pkg::NODE_IN_W-1:0] second_node;
	logic [wame_pkg::WEIGHT_W-1:0]  edge_weight;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [wame_pkg::KIND_W-1:0]    kind;
	logic [wame_pkg::NODE_IN_W-1:0] neighbor;
	logic [wame_pkg::WEIGHT_W-1:0]  weight;
	logic                           last;

	// shadow copy of the weight matrix and the beats still owed by the block
	logic [wame_pkg::WEIGHT_W-1:0] shadow_weights [wame_pkg::NODES][wame_pkg::NODES];
	adj_beat_t                     owed_beats [$];
	int                            mismatch_count = 0;
	int                            cycle_count = 0;
	bit                            calm;

	weighted_adjacency_matrix_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.first_node  (first_node),
		.second_node (second_node),
		.edge_weight (edge_weight),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.neighbor    (neighbor),
		.weight      (weight),
		.last        (last)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// queue a single beat
	task automatic owe_beat(input wame_pkg::kind_t k,
		input logic [wame_pkg::NODE_IN_W-1:0] nb,
		input logic [wame_pkg::WEIGHT_W-1:0] w, input logic lst);
		adj_beat_t b;
		b.kind     = k;
		b.neighbor = nb;
		b.weight   = w;
		b.last     = lst;
		owed_beats.push_back(b);
	endtask

	// apply one accepted item to the shadow graph and queue the beats it gives
	task automatic apply_graph_item(input logic cmd,
		input logic [wame_pkg::NODE_IN_W-1:0] a,
		input logic [wame_pkg::NODE_IN_W-1:0] b, input logic [wame_pkg::WEIGHT_W-1:0] w);
		int total;
		int seen;
		total = 0;
		seen  = 0;
		if (cmd == wame_pkg::CMD_MODIFY) begin
			if (a >= wame_pkg::NODES || b >= wame_pkg::NODES) begin
				owe_beat(wame_pkg::KIND_ERROR, '0, '0, 1'b1);
			end else begin
				shadow_weights[a][b] = w;
				shadow_weights[b][a] = w;
			end
		end else if (a >= wame_pkg::NODES) begin
			owe_beat(wame_pkg::KIND_ERROR, '0, '0, 1'b1);
		end else begin
			for (int i = 0; i < wame_pkg::NODES; i++)
				if (shadow_weights[a][i] != '0) total++;
			if (total == 0) begin
				owe_beat(wame_pkg::KIND_EMPTY, '0, '0, 1'b1);
			end else begin
				for (int i = 0; i < wame_pkg::NODES; i++) begin
					if (shadow_weights[a][i] != '0) begin
						seen++;
						owe_beat(wame_pkg::KIND_NEIGHBOR, wame_pkg::NODE_IN_W'(i),
							shadow_weights[a][i], seen == total);
					end
				end
			end
		end
	endtask

	// present one item and hold it until the accepting edge
	task automatic offer_item(input logic cmd, input logic [wame_pkg::NODE_IN_W-1:0] a,
		input logic [wame_pkg::NODE_IN_W-1:0] b, input logic [wame_pkg::WEIGHT_W-1:0] w);
		command     <= cmd;
		first_node  <= a;
		second_node <= b;
		edge_weight <= w;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// random gap on the input side after an accepted beat
	task automatic input_gap();
		int gap;
		gap = 0;
		while (!calm && $urandom_range(99) < IDLE_PERCENT) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
		end
	endtask

	// output side: random back-pressure and beat checking
	always @(posedge clk) begin
		adj_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_beats.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected beat, expected none, actual kind %0d neighbor %0d",
					$realtime, kind, neighbor);
			end else begin
				want = owed_beats.pop_front();
				compare_field("kind", int'(want.kind), int'(kind));
				compare_field("neighbor", int'(want.neighbor), int'(neighbor));
				compare_field("weight", int'(want.weight), int'(weight));
				compare_field("last", int'(want.last), int'(last));
			end
		end
		out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	// stimulus
	initial begin
		logic                           cmd;
		logic [wame_pkg::NODE_IN_W-1:0] a;
		logic [wame_pkg::NODE_IN_W-1:0] b;
		logic [wame_pkg::WEIGHT_W-1:0]  w;
		calm           = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = wame_pkg::CMD_QUERY;
		first_node     = '0;
		second_node    = '0;
		edge_weight    = '0;
		for (int r = 0; r < wame_pkg::NODES; r++)
			for (int c = 0; c < wame_pkg::NODES; c++)
				shadow_weights[r][c] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_item(DIRECTED[i].cmd, DIRECTED[i].node_a, DIRECTED[i].node_b,
				DIRECTED[i].new_weight);
			if (DIRECTED[i].fixed)
				owe_beat(DIRECTED[i].fixed_kind, '0, '0, 1'b1);
			else
				apply_graph_item(DIRECTED[i].cmd, DIRECTED[i].node_a, DIRECTED[i].node_b,
					DIRECTED[i].new_weight);
			input_gap();
		end

		// random edits and queries, mostly on valid nodes
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= CALM_FIRST && i < CALM_LAST);
			cmd  = ($urandom_range(99) < 55) ? wame_pkg::CMD_MODIFY : wame_pkg::CMD_QUERY;
			a    = ($urandom_range(99) < 10)
				? wame_pkg::NODE_IN_W'($urandom_range(31, wame_pkg::NODES))
				: wame_pkg::NODE_IN_W'($urandom_range(wame_pkg::NODES - 1, 0));
			b    = ($urandom_range(99) < 10)
				? wame_pkg::NODE_IN_W'($urandom_range(31, wame_pkg::NODES))
				: wame_pkg::NODE_IN_W'($urandom_range(wame_pkg::NODES - 1, 0));
			w    = ($urandom_range(99) < 15) ? '0
				: wame_pkg::WEIGHT_W'($urandom_range(255, 1));
			offer_item(cmd, a, b, w);
			apply_graph_item(cmd, a, b, w);
			input_gap();
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain
		while (owed_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
